// ===== hw/rtl/poi_pkg.sv =====
// Shared types, constants and the arctangent table of the planar odometry integrator.
package poi_pkg;

  localparam int unsigned SPEED_W = 21;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned HDG_W   = 32;
  // CORDIC datapath: Q6.26 speeds with headroom for the rotation gain
  localparam int unsigned CW      = 33;
  localparam int unsigned ATAN_IDX_W = 5;

  localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 21'sd524288;
  localparam logic signed [HDG_W-1:0]   PI_Q29      = 32'sd1686629713;
  localparam logic signed [HDG_W-1:0]   HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [35:0]        TWO_PI_Q29  = 36'sd3373259426;
  localparam logic signed [31:0]        GAIN_Q30    = 32'sd652032875;

  typedef struct packed {
    logic                 start;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_cmd_t;

  typedef struct packed {
    logic                 done;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } cordic_res_t;

  // atan(2^-i) in Q3.29, rounded to nearest
  function automatic logic [31:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd421657428;
      5'd1:  r = 32'd248918915;
      5'd2:  r = 32'd131521918;
      5'd3:  r = 32'd66762579;
      5'd4:  r = 32'd33510843;
      5'd5:  r = 32'd16771758;
      5'd6:  r = 32'd8387925;
      5'd7:  r = 32'd4194219;
      5'd8:  r = 32'd2097141;
      5'd9:  r = 32'd1048575;
      5'd10: r = 32'd524288;
      5'd11: r = 32'd262144;
      5'd12: r = 32'd131072;
      5'd13: r = 32'd65536;
      5'd14: r = 32'd32768;
      5'd15: r = 32'd16384;
      5'd16: r = 32'd8192;
      5'd17: r = 32'd4096;
      5'd18: r = 32'd2048;
      5'd19: r = 32'd1024;
      5'd20: r = 32'd512;
      5'd21: r = 32'd256;
      5'd22: r = 32'd128;
      5'd23: r = 32'd64;
      5'd24: r = 32'd32;
      5'd25: r = 32'd16;
      5'd26: r = 32'd8;
      5'd27: r = 32'd4;
      5'd28: r = 32'd2;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Clamp a speed field to plus or minus eight
  function automatic logic signed [SPEED_W-1:0] clamp_speed(
      input logic signed [SPEED_W-1:0] v);
    logic signed [SPEED_W-1:0] r;
    if (v > SPEED_LIMIT) begin
      r = SPEED_LIMIT;
    end else if (v < -SPEED_LIMIT) begin
      r = -SPEED_LIMIT;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/poi_if.sv =====
// Valid/ready channel interfaces for odometry inputs and pose results.
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] vel_forward;
  logic signed [20:0] vel_lateral;
  logic signed [20:0] yaw_rate;
  logic        [15:0] time_step;

  modport source (output valid, vel_forward, vel_lateral, yaw_rate, time_step,
                  input ready);
  modport sink   (input valid, vel_forward, vel_lateral, yaw_rate, time_step,
                  output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

// ===== hw/rtl/poi_cordic.sv =====
// Iterative CORDIC rotator: one shift-add micro-rotation per cycle.
module poi_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  poi_pkg::cordic_cmd_t cmd_i,
  output poi_pkg::cordic_res_t res_o
);

  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic signed [poi_pkg::CW-1:0] x_q, y_q, z_q;

  logic signed [poi_pkg::CW-1:0] xs, ys, ang;

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = $signed({1'b0, poi_pkg::atan_q29(poi_pkg::ATAN_IDX_W'(cnt_q))});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q <= cmd_i.x;
      y_q <= cmd_i.y;
      z_q <= cmd_i.z;
    end else if (busy_q) begin
      // rotate towards zero residual angle
      if (z_q >= 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.x    = x_q;
  assign res_o.y    = y_q;

endmodule

// ===== hw/rtl/planar_odometry_integrator.sv =====
// Top level of the planar dead-reckoning pose integrator.
//
// Each accepted transfer carries body forward and lateral speed, yaw rate and a
// time step; the block rotates the body velocity by the heading held before the
// step, adds the scaled displacement to x and y with saturation, advances and
// wraps the heading into (-pi, pi], then presents the new pose as one result.
// The result goes through CORDIC_STEPS micro-rotations of the CORDIC unit, five
// products through one registered 33 x 32 multiplier, two steps of heading
// correction (S_HDG, S_WRAP) and the load of the output register. The input is
// ready only in S_IDLE: it is not ready while an item is in work, also while a
// finished pose waits in S_EMIT for the output register to be taken.
// The pose registers clear to zero at reset.
module planar_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  poi_in_if.sink     in_i,
  poi_out_if.source  out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROTATE,
    S_MGY,
    S_MDX,
    S_MDY,
    S_MW,
    S_HDG,
    S_WRAP,
    S_EMIT
  } state_e;

  localparam int unsigned CW = poi_pkg::CW;

  state_e state_q;
  logic   out_valid_q;

  logic signed [31:0] pos_x_q, pos_y_q, heading_q;
  logic signed [31:0] out_x_q, out_y_q, out_h_q;
  logic signed [20:0] wz_q;
  logic        [15:0] dt_q;
  logic signed [64:0] prod_q;
  logic signed [CW-1:0] gx_q, gy_q;
  logic signed [35:0] h_q;

  logic               accept;
  logic signed [20:0] vf_c, vl_c;
  logic signed [CW-1:0] x0, y0;
  poi_pkg::cordic_cmd_t cor_cmd;
  poi_pkg::cordic_res_t cor_res;

  logic signed [CW-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [64:0]   prod_d;
  logic signed [33:0]   disp, pos_sum, pos_base;
  logic signed [31:0]   pos_sat;
  logic signed [35:0]   h_d;

  function automatic logic signed [35:0] wrap_once(input logic signed [35:0] h);
    logic signed [35:0] r;
    if (h > 36'(poi_pkg::PI_Q29)) begin
      r = h - poi_pkg::TWO_PI_Q29;
    end else if (h <= -36'(poi_pkg::PI_Q29)) begin
      r = h + poi_pkg::TWO_PI_Q29;
    end else begin
      r = h;
    end
    return r;
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Clamp, widen to Q6.26 and pre-rotate by a quarter turn where needed
  assign vf_c = poi_pkg::clamp_speed(in_i.vel_forward);
  assign vl_c = poi_pkg::clamp_speed(in_i.vel_lateral);
  assign x0   = CW'(vf_c) <<< 10;
  assign y0   = CW'(vl_c) <<< 10;

  always_comb begin
    cor_cmd.start = accept;
    if (heading_q > poi_pkg::HALF_PI_Q29) begin
      cor_cmd.x = -y0;
      cor_cmd.y = x0;
      cor_cmd.z = CW'(heading_q) - CW'(poi_pkg::HALF_PI_Q29);
    end else if (heading_q < -poi_pkg::HALF_PI_Q29) begin
      cor_cmd.x = y0;
      cor_cmd.y = -x0;
      cor_cmd.z = CW'(heading_q) + CW'(poi_pkg::HALF_PI_Q29);
    end else begin
      cor_cmd.x = x0;
      cor_cmd.y = y0;
      cor_cmd.z = CW'(heading_q);
    end
  end

  poi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .res_o  (cor_res)
  );

  // Shared multiplier operand selection
  always_comb begin
    case (state_q)
      S_ROTATE: begin
        mul_a = cor_res.x;
        mul_b = poi_pkg::GAIN_Q30;
      end
      S_MGY: begin
        mul_a = cor_res.y;
        mul_b = poi_pkg::GAIN_Q30;
      end
      S_MDX: begin
        mul_a = gx_q;
        mul_b = $signed({16'd0, dt_q});
      end
      S_MDY: begin
        mul_a = gy_q;
        mul_b = $signed({16'd0, dt_q});
      end
      S_MW: begin
        mul_a = CW'(wz_q);
        mul_b = $signed({16'd0, dt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = 65'(mul_a) * 65'(mul_b);

  // Saturating position add; one adder serves x then y
  assign disp     = 34'(prod_q >>> 26);
  assign pos_base = (state_q == S_MDY) ? 34'(pos_x_q) : 34'(pos_y_q);
  assign pos_sum  = pos_base + disp;

  always_comb begin
    if (pos_sum > 34'sh0_7FFF_FFFF) begin
      pos_sat = 32'sh7FFF_FFFF;
    end else if (pos_sum < -34'sh0_8000_0000) begin
      pos_sat = -32'sh8000_0000;
    end else begin
      pos_sat = 32'(pos_sum);
    end
  end

  assign h_d = wrap_once(36'(heading_q) + 36'(prod_q >>> 3));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
    end else begin
      if (state_q == S_EMIT && (!out_o.valid || out_o.ready)) begin
        out_valid_q <= 1'b1;
        out_x_q     <= pos_x_q;
        out_y_q     <= pos_y_q;
        out_h_q     <= heading_q;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          if (cor_res.done) begin
            state_q <= S_MGY;
          end
        end
        S_MGY: state_q <= S_MDX;
        S_MDX: state_q <= S_MDY;
        S_MDY: begin
          pos_x_q <= pos_sat;
          state_q <= S_MW;
        end
        S_MW: begin
          pos_y_q <= pos_sat;
          state_q <= S_HDG;
        end
        S_HDG: state_q <= S_WRAP;
        S_WRAP: begin
          heading_q <= 32'(wrap_once(h_q));
          state_q   <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (!out_o.valid || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      wz_q <= poi_pkg::clamp_speed(in_i.yaw_rate);
      dt_q <= in_i.time_step;
    end
    if (state_q == S_MGY) begin
      gx_q <= CW'(prod_q >>> 30);
    end
    if (state_q == S_MDX) begin
      gy_q <= CW'(prod_q >>> 30);
    end
    if (state_q == S_HDG) begin
      h_q <= h_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.pos_x   = out_x_q;
  assign out_o.pos_y   = out_y_q;
  assign out_o.heading = out_h_q;

  a_accept_starts_rotation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_ROTATE))
    else $error("accepted item did not start the rotator");

  a_done_only_when_rotating: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_res.done |-> (state_q == S_ROTATE))
    else $error("rotator finished outside the rotation phase");

  a_heading_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_q <= poi_pkg::PI_Q29) && (heading_q > -poi_pkg::PI_Q29))
    else $error("heading left (-pi, pi]");

  a_result_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result raised outside the emit step");

endmodule
